FILE: sv/fqs_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and helper functions for the searchable FIFO queue.
// No dependencies; every module of the block imports this package.
package fqs_pkg;

    // Queue geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths of the stream items
    localparam int KIND_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_FIELDS_W = STATUS_W + PTR_W + CNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_FIND  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic [PTR_W-1:0]   position;
        logic [CNT_W-1:0]   count;
        logic               empty;
    } result_t;

    // Request from the sequencer to the entry store
    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [PTR_W-1:0]      raddr;
    } mem_req_t;

    // Sign-extend or truncate the request word to the stored width
    function automatic logic [DATA_WIDTH-1:0] widen_word(input logic signed [VALUE_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // Circular pointer advance
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

endpackage

FILE: sv/fqs_store.sv
`timescale 1ns / 1ps
// Entry store of the queue: one write port, one registered read port.
// Depends on fqs_pkg.
module fqs_store
    import fqs_pkg::*;
(
    input  logic                  clk,
    input  mem_req_t              mem_req,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // Read port, data registered and valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fqs_seq.sv
`timescale 1ns / 1ps
// Request sequencer: pointers, count and the shared equality comparator
// that walks the entries for a find. Depends on fqs_pkg.
module fqs_seq
    import fqs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kind_t                 in_kind,
    input  logic [DATA_WIDTH-1:0] in_word,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res,
    output mem_req_t              mem_req,
    input  logic [DATA_WIDTH-1:0] rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [PTR_W-1:0]      cmp_idx_reg, cmp_idx_next;
    result_t               res_reg, res_next;
    logic                  hit;

    // Shared comparator
    assign hit = (rd_data == key_reg);

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        res_next       = res_reg;
        mem_req        = '0;
        mem_req.waddr  = tail_reg;
        mem_req.wdata  = in_word;
        mem_req.raddr  = rd_ptr_reg;
        in_ready       = (state_reg == S_IDLE);
        res_valid      = (state_reg == S_DONE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.status   = ST_OK;
                    res_next.position = '0;
                    state_next        = S_DONE;
                    case (in_kind)
                        KIND_PUSH:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we = 1'b1;
                                tail_next  = next_slot(tail_reg);
                                cnt_next   = cnt_reg + 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                head_next = next_slot(head_reg);
                                cnt_next  = cnt_reg - 1'b1;
                            end
                        end
                        KIND_FIND:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                key_next       = in_word;
                                rd_ptr_next    = head_reg;
                                issue_idx_next = '0;
                                cmp_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                head_next = '0;
                                tail_next = '0;
                                cnt_next  = '0;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                    res_next.count = cnt_next;
                    res_next.empty = (cnt_next == '0);
                end
            end

            S_SCAN:
            begin
                // issue the next read while comparing the previous word
                if (issue_idx_reg < cnt_reg)
                begin
                    mem_req.re     = 1'b1;
                    rd_ptr_next    = next_slot(rd_ptr_reg);
                    issue_idx_next = issue_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_idx_reg[PTR_W-1:0];
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg)
                begin
                    if (hit)
                    begin
                        res_next.status   = ST_OK;
                        res_next.position = cmp_idx_reg;
                        state_next        = S_DONE;
                    end
                    else if (CNT_W'(cmp_idx_reg) == cnt_reg - 1'b1)
                    begin
                        res_next.status   = ST_NOTFOUND;
                        res_next.position = '0;
                        state_next        = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            key_reg       <= '0;
            rd_ptr_reg    <= '0;
            issue_idx_reg <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            key_reg       <= key_next;
            rd_ptr_reg    <= rd_ptr_next;
            issue_idx_reg <= issue_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            res_reg       <= res_next;
        end
    end

    assign res = res_reg;

    // Expected tail from head and count, for the ring check
    logic [CNT_W:0] ring_sum;
    logic [CNT_W:0] ring_tail;
    assign ring_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(cnt_reg);
    assign ring_tail = (ring_sum >= (CNT_W + 1)'(DEPTH)) ? ring_sum - (CNT_W + 1)'(DEPTH)
                                                         : ring_sum;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_ring: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg == ring_tail[PTR_W-1:0])
        else $error("tail pointer out of step with head and count");

    a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_kind == KIND_PUSH && cnt_reg != CNT_W'(DEPTH))
        |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("accepted push did not grow the count");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cnt_reg != '0)
        else $error("scan running on an empty queue");

    a_cmp_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmp_valid_reg) |-> CNT_W'(cmp_idx_reg) < cnt_reg)
        else $error("compare index beyond held entries");

endmodule

FILE: sv/fifo_queue_with_search.sv
`timescale 1ns / 1ps
// Searchable FIFO queue, top level. Push, pop and clear set their result in
// the sequencer's result register on acceptance; find walks the held entries
// from the head with the one-word-per-cycle comparator, through the single
// read port of the entry store, until a hit or the last entry. The result then
// moves to the output register. One request at a time, the next taken the
// cycle after its result moves out. Reset (rst_n, async) empties it.
module fifo_queue_with_search
    import fqs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,  // value
    input  logic [KIND_W-1:0]      s_tuser,  // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // status, position, count, empty_res, zero pad
);

    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] in_word;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic                  m_valid_reg;
    result_t               out_reg;

    assign in_word = widen_word(s_tdata);

    fqs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (kind_t'(s_tuser)),
        .in_word   (in_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    fqs_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Output register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            out_reg     <= '0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
            out_reg     <= res;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_reg.empty, out_reg.count, out_reg.position,
                                    out_reg.status});

endmodule

FILE: test/tb_fifo_queue_with_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_search: a short directed table,
// then biased random push/pop/find/clear traffic checked against a shadow queue.
// Depends on fqs_pkg and the fifo_queue_with_search RTL.
module tb_fifo_queue_with_search;
    import fqs_pkg::*;

    localparam int DRAIN_CYCLES   = DEPTH + 12;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PER_PHASE = 475;
    localparam int LONG_HOLD      = 80;

    typedef struct {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        result_t            want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata;   // value
    logic [KIND_W-1:0]      s_tuser;   // kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // status, position, count, empty_res, zero pad

    // Shadow copy of the queue
    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    logic [PTR_W-1:0]      shadow_head;
    logic [PTR_W-1:0]      shadow_tail;
    int unsigned           shadow_fill;

    result_t     expected_results [$];
    stim_row_t   directed_rows [$];
    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned cycle_count;
    int unsigned push_count, pop_count, find_count, clear_count;
    int unsigned find_hits, full_rejects;
    int          src_idle_pct;
    int          sink_idle_pct;
    int unsigned sink_hold_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    fifo_queue_with_search DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic logic [PTR_W-1:0] bump_slot(logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % DEPTH);
    endfunction

    // Apply one request to the shadow queue and return the result it gives
    function automatic result_t predict_queue_op(kind_t kind, logic [VALUE_W-1:0] value);
        result_t               r;
        logic [DATA_WIDTH-1:0] word;
        logic [PTR_W-1:0]      slot;
        bit                    hit;
        r.status   = ST_OK;
        r.position = '0;
        word       = DATA_WIDTH'($signed(value));
        case (kind)
            KIND_PUSH:
            begin
                push_count++;
                if (shadow_fill == DEPTH)
                begin
                    r.status = ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    shadow_words[shadow_tail] = word;
                    shadow_tail = bump_slot(shadow_tail);
                    shadow_fill++;
                end
            end
            KIND_POP:
            begin
                pop_count++;
                if (shadow_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    shadow_head = bump_slot(shadow_head);
                    shadow_fill--;
                end
            end
            KIND_FIND:
            begin
                // walk from head toward tail, first match wins
                find_count++;
                hit  = 1'b0;
                slot = shadow_head;
                for (int i = 0; i < int'(shadow_fill) && !hit; i++)
                begin
                    if (shadow_words[slot] == word)
                    begin
                        hit        = 1'b1;
                        r.position = PTR_W'(i);
                    end
                    else
                    begin
                        slot = bump_slot(slot);
                    end
                end
                if (hit)
                begin
                    find_hits++;
                end
                else
                begin
                    r.status = ST_NOTFOUND;
                end
            end
            default:
            begin
                clear_count++;
                if (shadow_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    shadow_head = '0;
                    shadow_tail = '0;
                    shadow_fill = 0;
                end
            end
        endcase
        r.count = CNT_W'(shadow_fill);
        r.empty = (shadow_fill == 0);
        return r;
    endfunction

    // Random request mix; filling leans on push, draining on pop
    function automatic kind_t pick_kind(bit filling);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            return KIND_CLEAR;
        end
        if (roll < 28)
        begin
            return KIND_FIND;
        end
        if (filling)
        begin
            return (roll < 88) ? KIND_PUSH : KIND_POP;
        end
        return (roll < 45) ? KIND_PUSH : KIND_POP;
    endfunction

    // Mostly values already held or small repeats, so finds hit and duplicates occur
    function automatic logic [VALUE_W-1:0] pick_value();
        int               roll;
        logic [PTR_W-1:0] slot;
        roll = $urandom_range(99);
        if (roll < 40 && shadow_fill != 0)
        begin
            slot = PTR_W'((int'(shadow_head) + $urandom_range(shadow_fill - 1)) % DEPTH);
            return shadow_words[slot];
        end
        if (roll < 60)
        begin
            return VALUE_W'(int'($urandom_range(7)) - 4);
        end
        return $urandom;
    endfunction

    task automatic add_row(kind_t kind, logic [VALUE_W-1:0] value);
        stim_row_t row;
        row.kind  = kind;
        row.value = value;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked_row(kind_t kind, logic [VALUE_W-1:0] value, status_t st,
                                   int unsigned cnt, bit emp);
        stim_row_t row;
        row.kind          = kind;
        row.value         = value;
        row.typed         = 1'b1;
        row.want.status   = st;
        row.want.position = '0;
        row.want.count    = CNT_W'(cnt);
        row.want.empty    = emp;
        directed_rows.push_back(row);
    endtask

    // Offer one item, hold it until accepted, then record its expected result
    task automatic offer_item(kind_t kind, logic [VALUE_W-1:0] value, bit typed,
                              result_t want);
        result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = predict_queue_op(kind, value);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result side: random ready, with one long hold-off when the stimulus sets it
    initial
    begin : sink_drive
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status   = status_t'(m_tdata[STATUS_W-1:0]);
            got.position = m_tdata[STATUS_W +: PTR_W];
            got.count    = m_tdata[STATUS_W + PTR_W +: CNT_W];
            got.empty    = m_tdata[STATUS_W + PTR_W + CNT_W];
            result_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("ERROR: unexpected result status=%0d pos=%0d count=%0d empty=%0d",
                             got.status, got.position, got.count, got.empty);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.position !== want.position ||
                    got.count !== want.count || got.empty !== want.empty)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("ERROR: result %0d expected status=%0d pos=%0d count=%0d empty=%0d",
                                 result_count, want.status, want.position, want.count,
                                 want.empty);
                        $display("       got      status=%0d pos=%0d count=%0d empty=%0d",
                                 got.status, got.position, got.count, got.empty);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        bit                 filling;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = KIND_PUSH;
        shadow_head      = '0;
        shadow_tail      = '0;
        shadow_fill      = 0;
        sink_hold_cycles = 0;
        src_idle_pct     = 8;
        sink_idle_pct    = 53;
        filling          = 1'b1;

        // empty-queue corner cases
        add_checked_row(KIND_POP, '0, ST_EMPTY, 0, 1'b1);
        add_checked_row(KIND_CLEAR, 32'hFFFF_FFFF, ST_EMPTY, 0, 1'b1);
        add_checked_row(KIND_FIND, '0, ST_NOTFOUND, 0, 1'b1);
        // fill to capacity with the value extremes first
        add_row(KIND_PUSH, 32'h8000_0000);
        add_row(KIND_PUSH, 32'h7FFF_FFFF);
        add_row(KIND_PUSH, 32'h0000_0000);
        add_row(KIND_PUSH, 32'hFFFF_FFFF);
        for (int i = 0; i < 11; i++)
        begin
            add_row(KIND_PUSH, 32'h5A5A_0000 + 32'(i));
        end
        add_row(KIND_PUSH, 32'h1234_5678);
        add_checked_row(KIND_PUSH, 32'h0000_0001, ST_FULL, DEPTH, 1'b0);
        // match in the last slot, then a miss on a full queue
        add_row(KIND_FIND, 32'h1234_5678);
        add_row(KIND_FIND, 32'h0BAD_F00D);
        // popped head is no longer found
        add_row(KIND_POP, '0);
        add_row(KIND_FIND, 32'h8000_0000);
        add_checked_row(KIND_CLEAR, '0, ST_OK, 0, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].kind, directed_rows[i].value,
                       directed_rows[i].typed, directed_rows[i].want);
        end
        wait_all_results();

        // random traffic in three idling regimes
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 53 : 0;
            sink_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 8 : 0;
            if (phase == 2)
            begin
                // back-pressure: result side stalls while items keep coming
                sink_hold_cycles = LONG_HOLD;
            end
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (shadow_fill == DEPTH && $urandom_range(99) < 25)
                begin
                    filling = 1'b0;
                end
                else if (shadow_fill == 0)
                begin
                    filling = 1'b1;
                end
                kind  = pick_kind(filling);
                value = (kind == KIND_PUSH || kind == KIND_FIND) ? pick_value() : $urandom;
                offer_item(kind, value, 1'b0, '0);
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            mismatch_count += expected_results.size();
            $display("ERROR: %0d results never arrived", expected_results.size());
        end

        $display("Ran %0d pushes (%0d on a full queue), %0d pops, %0d finds (%0d hits), %0d clears",
                 push_count, full_rejects, pop_count, find_count, find_hits, clear_count);
        $display("Checked %0d results in %0d cycles, %0d mismatches",
                 result_count, cycle_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: fifo_queue_with_search.f
sv/fqs_pkg.sv
sv/fqs_store.sv
sv/fqs_seq.sv
sv/fifo_queue_with_search.sv
test/tb_fifo_queue_with_search.sv
